>>> rtl/ywz_pkg.sv
// Shared types, constants and codes for the YCbCr window zone pixel counter.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package ywz_pkg;

    // Frame geometry
    localparam int FRAME_COLUMNS = 180;
    localparam int FRAME_ROWS    = 120;

    // Field widths
    localparam int PIX_W   = 16;
    localparam int ROW_W   = 7;
    localparam int COL_W   = 8;
    localparam int TALLY_W = 15;
    localparam int NUM_TALLIES = 8;
    localparam int TALLY_IDX_W = $clog2(NUM_TALLIES);

    // Classification constants
    localparam logic [PIX_W-1:0]   GRAY_MARK      = 16'h07E0;
    localparam logic [7:0]         BLACK_LUMA_MAX = 8'd20;
    localparam logic [ROW_W-1:0]   ROW_LOW_START  = 7'd80;
    localparam logic [ROW_W-1:0]   ROW_MID_SPLIT  = 7'd100;
    localparam logic [COL_W-1:0]   COL_LEFT_END   = 8'd60;
    localparam logic [COL_W-1:0]   COL_MID_END    = 8'd120;
    localparam logic [TALLY_W-1:0] TALLY_MAX      = {TALLY_W{1'b1}};

    // Pixel classes
    localparam logic [1:0] CLASS_NONE  = 2'd0;
    localparam logic [1:0] CLASS_GRAY  = 2'd1;
    localparam logic [1:0] CLASS_BLACK = 2'd2;

    // Tally indexes
    localparam logic [TALLY_IDX_W-1:0] TALLY_LOW_LEFT      = 3'd0;
    localparam logic [TALLY_IDX_W-1:0] TALLY_LOW_MID_UPPER = 3'd1;
    localparam logic [TALLY_IDX_W-1:0] TALLY_LOW_MID_LOWER = 3'd2;
    localparam logic [TALLY_IDX_W-1:0] TALLY_LOW_RIGHT     = 3'd3;
    localparam logic [TALLY_IDX_W-1:0] TALLY_HIGH_LEFT     = 3'd4;
    localparam logic [TALLY_IDX_W-1:0] TALLY_HIGH_MID      = 3'd5;
    localparam logic [TALLY_IDX_W-1:0] TALLY_HIGH_RIGHT    = 3'd6;
    localparam logic [TALLY_IDX_W-1:0] TALLY_BLACK         = 3'd7;

    // Register map (index = paddr / 4)
    localparam int APB_AW  = 5;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_LUMA_MIN      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LUMA_MAX      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BLUE_DIFF_MIN = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BLUE_DIFF_MAX = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RED_DIFF_MIN  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RED_DIFF_MAX  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ROW_FIRST     = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ROW_END       = 3'd7;

    // Queue between classifier and counter stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0]       luma_min;
        logic [7:0]       luma_max;
        logic signed [7:0] blue_diff_min;
        logic signed [7:0] blue_diff_max;
        logic signed [7:0] red_diff_min;
        logic signed [7:0] red_diff_max;
        logic [ROW_W-1:0] row_first;
        logic [ROW_W-1:0] row_end;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0]       out_pixel;
        logic [1:0]             pixel_class;
        logic                   bump;
        logic [TALLY_IDX_W-1:0] tally_idx;
        logic                   clear;
    } t_item;

endpackage

>>> rtl/ywz_stream_if.sv
// Valid/ready stream interfaces for pixel input and classified results.
// Depends on ywz_pkg for field widths.
interface ywz_pix_if;
    logic                         valid;
    logic                         ready;
    logic [ywz_pkg::PIX_W-1:0]    pixel;
    logic [ywz_pkg::ROW_W-1:0]    row;
    logic [ywz_pkg::COL_W-1:0]    column;
    logic                         clear_counts;

    modport source (output valid, pixel, row, column, clear_counts, input ready);
    modport sink   (input valid, pixel, row, column, clear_counts, output ready);
endinterface

interface ywz_res_if;
    logic                         valid;
    logic                         ready;
    logic [ywz_pkg::PIX_W-1:0]    out_pixel;
    logic [1:0]                   pixel_class;
    logic [ywz_pkg::TALLY_W-1:0]  low_left_count;
    logic [ywz_pkg::TALLY_W-1:0]  low_mid_upper_count;
    logic [ywz_pkg::TALLY_W-1:0]  low_mid_lower_count;
    logic [ywz_pkg::TALLY_W-1:0]  low_right_count;
    logic [ywz_pkg::TALLY_W-1:0]  high_left_count;
    logic [ywz_pkg::TALLY_W-1:0]  high_mid_count;
    logic [ywz_pkg::TALLY_W-1:0]  high_right_count;
    logic [ywz_pkg::TALLY_W-1:0]  black_count;

    modport source (output valid, out_pixel, pixel_class, low_left_count,
                    low_mid_upper_count, low_mid_lower_count, low_right_count,
                    high_left_count, high_mid_count, high_right_count, black_count,
                    input ready);
    modport sink   (input valid, out_pixel, pixel_class, low_left_count,
                    low_mid_upper_count, low_mid_lower_count, low_right_count,
                    high_left_count, high_mid_count, high_right_count, black_count,
                    output ready);
endinterface

>>> rtl/ywz_front.sv
// Front end: accepts pixels, converts RGB565 to YCbCr and classifies them.
// Depends on ywz_pkg and ywz_pix_if; feeds one classified item to the queue.
module ywz_front (
    ywz_pix_if.sink               i_pix,
    input  ywz_pkg::t_cfg         i_cfg,
    input  logic                  i_queue_full,
    output logic                  o_push,
    output ywz_pkg::t_item        o_item
);

    logic [7:0]         r8, g8, b8;
    logic signed [17:0] rs, gs, bs;
    logic [15:0]        y_sum;
    logic signed [17:0] cb_sum, cr_sum;
    logic [7:0]         luma;
    logic signed [8:0]  cb, cr;
    logic signed [8:0]  cb_lo, cb_hi, cr_lo, cr_hi;
    logic               in_window, chroma_ok, is_gray, is_black, row_low;

    assign r8 = {i_pix.pixel[15:11], 3'b000};
    assign g8 = {i_pix.pixel[10:5], 2'b00};
    assign b8 = {i_pix.pixel[4:0], 3'b000};
    assign rs = $signed({10'd0, r8});
    assign gs = $signed({10'd0, g8});
    assign bs = $signed({10'd0, b8});

    // Luma sum tops out below 2^16, so bits 15:8 are the rounded result
    assign y_sum = 16'd77 * {8'd0, r8} + 16'd150 * {8'd0, g8}
                 + 16'd29 * {8'd0, b8} + 16'd128;
    assign luma  = y_sum[15:8];

    // Chroma sums stay within 17 signed bits; dropping 8 LSBs floors them
    assign cb_sum = 18'sd128 * bs - 18'sd43 * rs - 18'sd85 * gs - 18'sd128;
    assign cr_sum = 18'sd128 * rs - 18'sd107 * gs - 18'sd21 * bs - 18'sd128;
    assign cb     = cb_sum[16:8];
    assign cr     = cr_sum[16:8];

    assign cb_lo = {i_cfg.blue_diff_min[7], i_cfg.blue_diff_min};
    assign cb_hi = {i_cfg.blue_diff_max[7], i_cfg.blue_diff_max};
    assign cr_lo = {i_cfg.red_diff_min[7], i_cfg.red_diff_min};
    assign cr_hi = {i_cfg.red_diff_max[7], i_cfg.red_diff_max};

    assign in_window = (i_pix.row >= i_cfg.row_first) && (i_pix.row < i_cfg.row_end)
                    && (i_pix.row < ywz_pkg::ROW_W'(ywz_pkg::FRAME_ROWS));
    assign chroma_ok = (cb >= cb_lo) && (cb <= cb_hi) && (cr >= cr_lo) && (cr <= cr_hi);
    assign is_gray   = in_window && chroma_ok
                    && (luma >= i_cfg.luma_min) && (luma <= i_cfg.luma_max);
    assign is_black  = in_window && chroma_ok && !is_gray
                    && (luma <= ywz_pkg::BLACK_LUMA_MAX);
    assign row_low   = i_pix.row >= ywz_pkg::ROW_LOW_START;

    assign i_pix.ready = !i_queue_full;
    assign o_push      = i_pix.valid && !i_queue_full;

    always_comb begin
        o_item.out_pixel   = i_pix.pixel;
        o_item.pixel_class = ywz_pkg::CLASS_NONE;
        o_item.bump        = 1'b0;
        o_item.tally_idx   = ywz_pkg::TALLY_BLACK;
        o_item.clear       = i_pix.clear_counts;
        if (is_gray) begin
            o_item.out_pixel   = i_pix.pixel | ywz_pkg::GRAY_MARK;
            o_item.pixel_class = ywz_pkg::CLASS_GRAY;
            o_item.bump        = i_pix.column < ywz_pkg::COL_W'(ywz_pkg::FRAME_COLUMNS);
            if (i_pix.column < ywz_pkg::COL_LEFT_END) begin
                o_item.tally_idx = row_low ? ywz_pkg::TALLY_LOW_LEFT
                                           : ywz_pkg::TALLY_HIGH_LEFT;
            end else if (i_pix.column < ywz_pkg::COL_MID_END) begin
                if (!row_low) begin
                    o_item.tally_idx = ywz_pkg::TALLY_HIGH_MID;
                end else if (i_pix.row < ywz_pkg::ROW_MID_SPLIT) begin
                    o_item.tally_idx = ywz_pkg::TALLY_LOW_MID_UPPER;
                end else begin
                    o_item.tally_idx = ywz_pkg::TALLY_LOW_MID_LOWER;
                end
            end else begin
                o_item.tally_idx = row_low ? ywz_pkg::TALLY_LOW_RIGHT
                                           : ywz_pkg::TALLY_HIGH_RIGHT;
            end
        end else if (is_black) begin
            o_item.pixel_class = ywz_pkg::CLASS_BLACK;
            o_item.bump        = 1'b1;
            o_item.tally_idx   = ywz_pkg::TALLY_BLACK;
        end
    end

endmodule

>>> rtl/ywz_queue.sv
// Short FIFO of classified items between the front end and the counter stage.
// Depends on ywz_pkg for the item type and depth.
module ywz_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ywz_pkg::t_item        i_item,
    input  logic                  i_pop,
    output logic                  o_valid,
    output logic                  o_full,
    output ywz_pkg::t_item        o_item
);

    ywz_pkg::t_item                  r_mem [ywz_pkg::QUEUE_DEPTH];
    logic [ywz_pkg::QUEUE_AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [ywz_pkg::QUEUE_AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [ywz_pkg::QUEUE_AW:0]      r_count, n_count;
    logic                            do_push, do_pop;

    assign o_valid = r_count != '0;
    assign o_full  = r_count == (ywz_pkg::QUEUE_AW + 1)'(ywz_pkg::QUEUE_DEPTH);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> rtl/ywz_back.sv
// Back end: applies clears, bumps saturating zone tallies, holds the result register.
// Depends on ywz_pkg and ywz_res_if; drains items from ywz_queue.
module ywz_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  ywz_pkg::t_item        i_q_item,
    output logic                  o_pop,
    ywz_res_if.source             o_res
);

    logic [ywz_pkg::NUM_TALLIES-1:0][ywz_pkg::TALLY_W-1:0] r_tally, n_tally;
    logic                          r_valid, n_valid;
    logic [ywz_pkg::PIX_W-1:0]     r_pixel;
    logic [1:0]                    r_class;
    logic [ywz_pkg::TALLY_W-1:0]   base;

    // Take a new item whenever the result register is empty or being drained
    assign o_pop = i_q_valid && (!r_valid || o_res.ready);

    always_comb begin
        n_tally = r_tally;
        base    = '0;
        if (o_pop) begin
            for (int i = 0; i < ywz_pkg::NUM_TALLIES; i++) begin
                base = i_q_item.clear ? '0 : r_tally[i];
                if (i_q_item.bump && (i_q_item.tally_idx == ywz_pkg::TALLY_IDX_W'(i))
                    && (base != ywz_pkg::TALLY_MAX)) begin
                    base = base + 1'b1;
                end
                n_tally[i] = base;
            end
        end
        n_valid = o_pop ? 1'b1 : (r_valid && !o_res.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tally <= '0;
        end else begin
            r_valid <= n_valid;
            r_tally <= n_tally;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pixel <= i_q_item.out_pixel;
            r_class <= i_q_item.pixel_class;
        end
    end

    assign o_res.valid               = r_valid;
    assign o_res.out_pixel           = r_pixel;
    assign o_res.pixel_class         = r_class;
    assign o_res.low_left_count      = r_tally[ywz_pkg::TALLY_LOW_LEFT];
    assign o_res.low_mid_upper_count = r_tally[ywz_pkg::TALLY_LOW_MID_UPPER];
    assign o_res.low_mid_lower_count = r_tally[ywz_pkg::TALLY_LOW_MID_LOWER];
    assign o_res.low_right_count     = r_tally[ywz_pkg::TALLY_LOW_RIGHT];
    assign o_res.high_left_count     = r_tally[ywz_pkg::TALLY_HIGH_LEFT];
    assign o_res.high_mid_count      = r_tally[ywz_pkg::TALLY_HIGH_MID];
    assign o_res.high_right_count    = r_tally[ywz_pkg::TALLY_HIGH_RIGHT];
    assign o_res.black_count         = r_tally[ywz_pkg::TALLY_BLACK];

    // Tallies move only when a new result is loaded
    a_tally_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_pop |=> $stable(r_tally))
        else $error("tallies changed without a new result");

    // A clearing item that counts nothing leaves every tally at zero
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_q_item.clear && !i_q_item.bump) |=> (r_tally == '0))
        else $error("tallies not zero after clear");

    // The black tally moves without a clear only for a black result
    a_black_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !i_q_item.clear) ##1 !$stable(r_tally[ywz_pkg::TALLY_BLACK])
        |-> (r_class == ywz_pkg::CLASS_BLACK))
        else $error("black tally bumped for a non-black pixel");

endmodule

>>> rtl/ycbcr_window_zone_pixel_counter.sv
// Top level of the YCbCr window zone pixel counter: APB registers, front, queue, back.
// Depends on ywz_pkg, ywz_stream_if, ywz_front, ywz_queue and ywz_back.
//
// The block takes one RGB565 pixel with its row, column and a clear flag per
// transfer and returns one result per pixel: the pixel (ORed with 0x07E0 when
// classed gray), its class (none, gray, black) and eight 15-bit saturating
// tallies as they stand after that pixel. A pixel is examined only in rows
// row_first <= row < row_end; gray needs Y, Cb and Cr inside the configured
// bounds, black needs Y <= 20 with Cb and Cr in bounds. Gray pixels inside the
// frame columns count in one of seven screen zones, black pixels in the black
// tally; a set clear flag zeros all tallies before the pixel counts.
// Throughput is one pixel per cycle while results are taken: the front end
// converts and classifies in the cycle of the input transfer, a four-entry
// queue holds classified pixels, and the back end updates the tallies and
// loads the result register together, so a result is registered in the queue
// and then in the result register before it goes valid. The input side keeps
// accepting while results stall until the queue fills. Registers sit at byte
// address 4*index on the APB port (luma_min, luma_max, blue_diff_min,
// blue_diff_max, red_diff_min, red_diff_max, row_first, row_end) and must be
// written only while no pixel is in flight.
module ycbcr_window_zone_pixel_counter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ywz_pix_if.sink                       i_pix,
    ywz_res_if.source                     o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ywz_pkg::APB_AW-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    ywz_pkg::t_cfg                 r_cfg;
    logic                          cfg_write;
    logic [ywz_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          push, pop, q_valid, q_full;
    ywz_pkg::t_item                front_item, q_item;

    // Register file: no wait states, write on the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[ywz_pkg::APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.luma_min      <= 8'd70;
            r_cfg.luma_max      <= 8'd140;
            r_cfg.blue_diff_min <= -8'sd10;
            r_cfg.blue_diff_max <= 8'sd10;
            r_cfg.red_diff_min  <= -8'sd10;
            r_cfg.red_diff_max  <= 8'sd10;
            r_cfg.row_first     <= 7'd60;
            r_cfg.row_end       <= 7'd120;
        end else if (cfg_write) begin
            unique case (reg_idx)
                ywz_pkg::REG_LUMA_MIN:      r_cfg.luma_min      <= pwdata[7:0];
                ywz_pkg::REG_LUMA_MAX:      r_cfg.luma_max      <= pwdata[7:0];
                ywz_pkg::REG_BLUE_DIFF_MIN: r_cfg.blue_diff_min <= pwdata[7:0];
                ywz_pkg::REG_BLUE_DIFF_MAX: r_cfg.blue_diff_max <= pwdata[7:0];
                ywz_pkg::REG_RED_DIFF_MIN:  r_cfg.red_diff_min  <= pwdata[7:0];
                ywz_pkg::REG_RED_DIFF_MAX:  r_cfg.red_diff_max  <= pwdata[7:0];
                ywz_pkg::REG_ROW_FIRST:     r_cfg.row_first     <= pwdata[6:0];
                ywz_pkg::REG_ROW_END:       r_cfg.row_end       <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // Read back; signed bounds come back sign-extended
    always_comb begin
        unique case (reg_idx)
            ywz_pkg::REG_LUMA_MIN:      prdata = {24'd0, r_cfg.luma_min};
            ywz_pkg::REG_LUMA_MAX:      prdata = {24'd0, r_cfg.luma_max};
            ywz_pkg::REG_BLUE_DIFF_MIN: prdata = 32'(r_cfg.blue_diff_min);
            ywz_pkg::REG_BLUE_DIFF_MAX: prdata = 32'(r_cfg.blue_diff_max);
            ywz_pkg::REG_RED_DIFF_MIN:  prdata = 32'(r_cfg.red_diff_min);
            ywz_pkg::REG_RED_DIFF_MAX:  prdata = 32'(r_cfg.red_diff_max);
            ywz_pkg::REG_ROW_FIRST:     prdata = {25'd0, r_cfg.row_first};
            ywz_pkg::REG_ROW_END:       prdata = {25'd0, r_cfg.row_end};
            default:                    prdata = '0;
        endcase
    end

    // Classify in the front end, queue, then count in the back end
    ywz_front u_front (
        .i_pix        (i_pix),
        .i_cfg        (r_cfg),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_item       (front_item)
    );

    ywz_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_item  (q_item)
    );

    ywz_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_pop     (pop),
        .o_res     (o_res)
    );

endmodule

>>> tb/sv/tb_ycbcr_window_zone_pixel_counter.sv
`timescale 1ns / 100ps
// Self-checking testbench for ycbcr_window_zone_pixel_counter: random and directed pixel streams.
// Depends on ywz_pkg, the ywz_pix_if / ywz_res_if stream interfaces and the RTL top level.
module tb_ycbcr_window_zone_pixel_counter;
    import ywz_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 4;      // settling margin after the last result
    localparam int BURST_ROUNDS   = 4;

    // Sample pixels used by the directed part
    localparam logic [PIX_W-1:0] PIX_MID_GRAY = 16'h632C;   // Y=98, Cb=-2, Cr=-3
    localparam logic [PIX_W-1:0] PIX_BLACK    = 16'h0000;   // Y=0,  Cb=-1, Cr=-1
    localparam logic [PIX_W-1:0] PIX_WHITE    = 16'hFFFF;   // Y=250
    localparam logic [PIX_W-1:0] PIX_RED      = 16'hF800;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic             clear_counts;
    } t_pix_item;

    typedef struct packed {
        logic [PIX_W-1:0]                     out_pixel;
        logic [1:0]                           pixel_class;
        logic [NUM_TALLIES-1:0][TALLY_W-1:0]  tally;
    } t_zone_result;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [APB_AW-1:0] paddr;
    logic [31:0] pwdata, prdata;

    ywz_pix_if pix_bus ();
    ywz_res_if res_bus ();

    ycbcr_window_zone_pixel_counter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: register shadow and the eight saturating tallies
    t_cfg                                window_cfg;
    logic [NUM_TALLIES-1:0][TALLY_W-1:0] zone_tally;

    t_pix_item    pixel_backlog[$];     // items waiting for the driver
    t_zone_result expected_results[$];  // predictions waiting for the DUT
    int           items_queued;
    int           items_taken;
    int           error_count;
    int           quiet_cycles;

    int  src_idle_pct;
    int  sink_idle_pct;
    bit  hold_arm;
    bit  hold_used;
    int  hold_left;
    bit  pix_taken;

    t_pix_item    next_px;
    t_zone_result got_res;
    t_zone_result want_res;

    string tally_label [NUM_TALLIES] = '{"low_left", "low_mid_upper", "low_mid_lower",
        "low_right", "high_left", "high_mid", "high_right", "black"};

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    task automatic flag_error(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic void bump_tally(input logic [TALLY_IDX_W-1:0] idx);
        // Hold at full scale instead of wrapping
        if (zone_tally[idx] != TALLY_MAX) zone_tally[idx] = zone_tally[idx] + 1'b1;
    endfunction

    // Convert, classify and count one pixel; advances the tally shadow.
    function automatic t_zone_result classify_and_tally(input t_pix_item it);
        t_zone_result r;
        int red, grn, blu, luma, cb, cr;
        bit chroma_ok, in_rows;
        if (it.clear_counts) zone_tally = '0;
        r.out_pixel   = it.pixel;
        r.pixel_class = CLASS_NONE;
        in_rows = (it.row >= window_cfg.row_first) && (it.row < window_cfg.row_end) &&
                  (it.row < FRAME_ROWS);
        if (in_rows) begin
            red  = int'(it.pixel[15:11]) * 8;
            grn  = int'(it.pixel[10:5]) * 4;
            blu  = int'(it.pixel[4:0]) * 8;
            luma = (77 * red + 150 * grn + 29 * blu + 128) >>> 8;
            // Arithmetic shift of a signed int floors toward minus infinity
            cb   = (-43 * red - 85 * grn + 128 * blu - 128) >>> 8;
            cr   = (128 * red - 107 * grn - 21 * blu - 128) >>> 8;
            chroma_ok = (cb >= int'(window_cfg.blue_diff_min)) &&
                        (cb <= int'(window_cfg.blue_diff_max)) &&
                        (cr >= int'(window_cfg.red_diff_min)) &&
                        (cr <= int'(window_cfg.red_diff_max));
            if (chroma_ok && luma >= int'(window_cfg.luma_min) &&
                luma <= int'(window_cfg.luma_max)) begin
                r.pixel_class = CLASS_GRAY;
                r.out_pixel   = it.pixel | GRAY_MARK;
                // Columns past the frame are marked but land in no zone
                if (it.row >= ROW_LOW_START) begin
                    if (it.column < COL_LEFT_END) bump_tally(TALLY_LOW_LEFT);
                    else if (it.column < COL_MID_END && it.row < ROW_MID_SPLIT)
                        bump_tally(TALLY_LOW_MID_UPPER);
                    else if (it.column < COL_MID_END) bump_tally(TALLY_LOW_MID_LOWER);
                    else if (it.column < FRAME_COLUMNS) bump_tally(TALLY_LOW_RIGHT);
                end else begin
                    if (it.column < COL_LEFT_END) bump_tally(TALLY_HIGH_LEFT);
                    else if (it.column < COL_MID_END) bump_tally(TALLY_HIGH_MID);
                    else if (it.column < FRAME_COLUMNS) bump_tally(TALLY_HIGH_RIGHT);
                end
            end else if (chroma_ok && luma <= int'(BLACK_LUMA_MAX)) begin
                r.pixel_class = CLASS_BLACK;
                bump_tally(TALLY_BLACK);
            end
        end
        r.tally = zone_tally;
        return r;
    endfunction

    // Input driver: present the next backlog item, hold it until the transfer.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pix_bus.valid <= 1'b0;
        end else if (!pix_bus.valid || pix_taken) begin
            if (pixel_backlog.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                next_px = pixel_backlog.pop_front();
                pix_bus.valid        <= 1'b1;
                pix_bus.pixel        <= next_px.pixel;
                pix_bus.row          <= next_px.row;
                pix_bus.column       <= next_px.column;
                pix_bus.clear_counts <= next_px.clear_counts;
            end else begin
                pix_bus.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_arm && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Predict at every input transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && pix_bus.valid && pix_bus.ready) begin
            next_px.pixel        = pix_bus.pixel;
            next_px.row          = pix_bus.row;
            next_px.column       = pix_bus.column;
            next_px.clear_counts = pix_bus.clear_counts;
            expected_results.push_back(classify_and_tally(next_px));
            items_taken++;
        end
        pix_taken <= i_rst_n && pix_bus.valid && pix_bus.ready;
    end

    // Check every result transfer against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            got_res.out_pixel                 = res_bus.out_pixel;
            got_res.pixel_class               = res_bus.pixel_class;
            got_res.tally[TALLY_LOW_LEFT]      = res_bus.low_left_count;
            got_res.tally[TALLY_LOW_MID_UPPER] = res_bus.low_mid_upper_count;
            got_res.tally[TALLY_LOW_MID_LOWER] = res_bus.low_mid_lower_count;
            got_res.tally[TALLY_LOW_RIGHT]     = res_bus.low_right_count;
            got_res.tally[TALLY_HIGH_LEFT]     = res_bus.high_left_count;
            got_res.tally[TALLY_HIGH_MID]      = res_bus.high_mid_count;
            got_res.tally[TALLY_HIGH_RIGHT]    = res_bus.high_right_count;
            got_res.tally[TALLY_BLACK]         = res_bus.black_count;
            if (expected_results.size() == 0) begin
                flag_error($sformatf("result with nothing expected, pixel %h",
                                     got_res.out_pixel));
            end else begin
                want_res = expected_results.pop_front();
                if (got_res.out_pixel !== want_res.out_pixel)
                    flag_error($sformatf("out_pixel %h, want %h",
                                         got_res.out_pixel, want_res.out_pixel));
                if (got_res.pixel_class !== want_res.pixel_class)
                    flag_error($sformatf("pixel_class %0d, want %0d",
                                         got_res.pixel_class, want_res.pixel_class));
                for (int k = 0; k < NUM_TALLIES; k++) begin
                    if (got_res.tally[k] !== want_res.tally[k])
                        flag_error($sformatf("%s_count %0d, want %0d", tally_label[k],
                                             got_res.tally[k], want_res.tally[k]));
                end
            end
        end
    end

    // Watchdog: end the run if no transfer happens for too long.
    always @(posedge i_clk) begin
        if ((pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // One APB write: setup, then access; shadow follows at the write edge.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        // Junk in the upper bits must be dropped by the register
        pwdata  = ($urandom() & 32'hFFFF_FF00) | 32'(value);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_LUMA_MIN:      window_cfg.luma_min      = value;
            REG_LUMA_MAX:      window_cfg.luma_max      = value;
            REG_BLUE_DIFF_MIN: window_cfg.blue_diff_min = value;
            REG_BLUE_DIFF_MAX: window_cfg.blue_diff_max = value;
            REG_RED_DIFF_MIN:  window_cfg.red_diff_min  = value;
            REG_RED_DIFF_MAX:  window_cfg.red_diff_max  = value;
            REG_ROW_FIRST:     window_cfg.row_first     = value[ROW_W-1:0];
            REG_ROW_END:       window_cfg.row_end       = value[ROW_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic program_window(input t_cfg c);
        write_reg(REG_LUMA_MIN,      c.luma_min);
        write_reg(REG_LUMA_MAX,      c.luma_max);
        write_reg(REG_BLUE_DIFF_MIN, c.blue_diff_min);
        write_reg(REG_BLUE_DIFF_MAX, c.blue_diff_max);
        write_reg(REG_RED_DIFF_MIN,  c.red_diff_min);
        write_reg(REG_RED_DIFF_MAX,  c.red_diff_max);
        write_reg(REG_ROW_FIRST,     {1'b0, c.row_first});
        write_reg(REG_ROW_END,       {1'b0, c.row_end});
    endtask

    task automatic push_item(input logic [PIX_W-1:0] pixel, input int row, input int column,
                             input bit clear);
        t_pix_item it;
        it.pixel        = pixel;
        it.row          = ROW_W'(row);
        it.column       = COL_W'(column);
        it.clear_counts = clear;
        pixel_backlog.push_back(it);
        items_queued++;
    endtask

    // Random pixel: 55 percent near-neutral so gray and black show up, the rest anything.
    task automatic push_random_pixels(input int count);
        int r5, g6, b5, lo, hi, row, column;
        logic [PIX_W-1:0] pixel;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 55) begin
                r5 = $urandom_range(31);
                g6 = 2 * r5 + int'($urandom_range(6)) - 3;
                b5 = r5 + int'($urandom_range(4)) - 2;
                if (g6 < 0) g6 = 0;
                if (g6 > 63) g6 = 63;
                if (b5 < 0) b5 = 0;
                if (b5 > 31) b5 = 31;
                pixel = {5'(r5), 6'(g6), 5'(b5)};
            end else begin
                pixel = PIX_W'($urandom());
            end
            lo = window_cfg.row_first;
            hi = (window_cfg.row_end < FRAME_ROWS) ? window_cfg.row_end : FRAME_ROWS;
            if ($urandom_range(99) < 4)
                row = $urandom_range(127, FRAME_ROWS);
            else if (lo < hi && $urandom_range(99) < 88)
                row = $urandom_range(hi - 1, lo);
            else
                row = $urandom_range(FRAME_ROWS - 1);
            if ($urandom_range(99) < 5)
                column = $urandom_range(255, FRAME_COLUMNS);
            else
                column = $urandom_range(FRAME_COLUMNS - 1);
            push_item(pixel, row, column, $urandom_range(99) < 4);
        end
    endtask

    function automatic t_cfg random_window_cfg();
        t_cfg c;
        int first;
        c.luma_min      = 8'($urandom_range(120));
        c.luma_max      = 8'($urandom_range(255, 60));
        c.blue_diff_min = 8'(-int'($urandom_range(25)));
        c.blue_diff_max = 8'($urandom_range(25));
        c.red_diff_min  = 8'(-int'($urandom_range(25)));
        c.red_diff_max  = 8'($urandom_range(25));
        first           = $urandom_range(90);
        c.row_first     = ROW_W'(first);
        c.row_end       = ROW_W'($urandom_range(FRAME_ROWS, first + 1));
        return c;
    endfunction

    // Wait until every item went in and every result came out, then settle.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (items_taken != items_queued || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    t_cfg phase_cfg;

    initial begin
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        pix_bus.valid        = 1'b0;
        pix_bus.pixel        = '0;
        pix_bus.row          = '0;
        pix_bus.column       = '0;
        pix_bus.clear_counts = 1'b0;
        res_bus.ready        = 1'b0;
        items_queued         = 0;
        items_taken          = 0;
        error_count          = 0;
        quiet_cycles         = 0;
        hold_arm             = 1'b0;
        hold_used            = 1'b0;
        hold_left            = 0;
        pix_taken            = 1'b0;
        src_idle_pct         = 16;
        sink_idle_pct        = 16;
        zone_tally           = '0;
        window_cfg.luma_min      = 8'd70;
        window_cfg.luma_max      = 8'd140;
        window_cfg.blue_diff_min = -8'sd10;
        window_cfg.blue_diff_max = 8'sd10;
        window_cfg.red_diff_min  = -8'sd10;
        window_cfg.red_diff_max  = 8'sd10;
        window_cfg.row_first     = 7'd60;
        window_cfg.row_end       = 7'd120;

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        // Directed pass on reset settings: each zone at its corners, the
        // beyond-frame columns, rows outside the window, black, clear.
        push_item(PIX_MID_GRAY, 60, 0, 1'b1);
        push_item(PIX_MID_GRAY, 79, 59, 1'b0);
        push_item(PIX_MID_GRAY, 70, 60, 1'b0);
        push_item(PIX_MID_GRAY, 79, 119, 1'b0);
        push_item(PIX_MID_GRAY, 60, 120, 1'b0);
        push_item(PIX_MID_GRAY, 79, 179, 1'b0);
        push_item(PIX_MID_GRAY, 80, 0, 1'b0);
        push_item(PIX_MID_GRAY, 119, 59, 1'b0);
        push_item(PIX_MID_GRAY, 80, 60, 1'b0);
        push_item(PIX_MID_GRAY, 99, 119, 1'b0);
        push_item(PIX_MID_GRAY, 100, 60, 1'b0);
        push_item(PIX_MID_GRAY, 119, 119, 1'b0);
        push_item(PIX_MID_GRAY, 80, 120, 1'b0);
        push_item(PIX_MID_GRAY, 119, 179, 1'b0);
        push_item(PIX_MID_GRAY, 70, 180, 1'b0);
        push_item(PIX_MID_GRAY, 90, 255, 1'b0);
        push_item(PIX_BLACK, 60, 0, 1'b0);
        push_item(PIX_WHITE, 119, 179, 1'b0);
        push_item(PIX_MID_GRAY, 59, 10, 1'b0);
        push_item(PIX_MID_GRAY, 0, 0, 1'b0);
        push_item(PIX_BLACK, 120, 5, 1'b0);
        push_item(PIX_RED, 65, 10, 1'b0);
        push_item(PIX_MID_GRAY, 100, 100, 1'b1);
        push_item(PIX_WHITE, 127, 255, 1'b1);
        push_item(PIX_BLACK, 119, 179, 1'b0);
        wait_drained();

        // Everything open: every examined pixel is gray
        phase_cfg.luma_min      = 8'd0;
        phase_cfg.luma_max      = 8'd255;
        phase_cfg.blue_diff_min = -8'sd128;
        phase_cfg.blue_diff_max = 8'sd127;
        phase_cfg.red_diff_min  = -8'sd128;
        phase_cfg.red_diff_max  = 8'sd127;
        phase_cfg.row_first     = 7'd0;
        phase_cfg.row_end       = 7'd120;
        program_window(phase_cfg);
        push_random_pixels(80);
        wait_drained();

        // Inverted luma bounds: gray impossible, only black can count
        phase_cfg.luma_min = 8'd255;
        phase_cfg.luma_max = 8'd0;
        program_window(phase_cfg);
        push_random_pixels(60);
        wait_drained();

        // Empty row window, then inverted row window, inverted chroma
        phase_cfg.luma_min  = 8'd70;
        phase_cfg.luma_max  = 8'd140;
        phase_cfg.row_first = 7'd50;
        phase_cfg.row_end   = 7'd50;
        program_window(phase_cfg);
        push_random_pixels(30);
        wait_drained();
        phase_cfg.row_first     = 7'd100;
        phase_cfg.row_end       = 7'd40;
        phase_cfg.blue_diff_min = 8'sd127;
        phase_cfg.blue_diff_max = -8'sd128;
        program_window(phase_cfg);
        push_random_pixels(30);
        wait_drained();

        // Random settings; one phase without idling, one with a long hold-off
        for (int ph = 0; ph < 4; ph++) begin
            program_window(random_window_cfg());
            src_idle_pct  = (ph == 1) ? 0 : 16;
            sink_idle_pct = (ph == 1) ? 0 : 16;
            if (ph == 2) hold_arm = 1'b1;
            push_random_pixels(ph == 2 ? 120 : 60);
            wait_drained();
        end

        // Dense counting burst: round-robin over the seven zones and black,
        // rows extended past the frame so the frame-row limit applies.
        src_idle_pct            = 0;
        sink_idle_pct           = 0;
        phase_cfg.luma_min      = 8'd21;
        phase_cfg.luma_max      = 8'd255;
        phase_cfg.blue_diff_min = -8'sd128;
        phase_cfg.blue_diff_max = 8'sd127;
        phase_cfg.red_diff_min  = -8'sd128;
        phase_cfg.red_diff_max  = 8'sd127;
        phase_cfg.row_first     = 7'd0;
        phase_cfg.row_end       = 7'd127;
        program_window(phase_cfg);
        push_item(PIX_BLACK, 125, 0, 1'b1);
        for (int n = 0; n < BURST_ROUNDS; n++) begin
            push_item(PIX_MID_GRAY, 10, 0, 1'b0);
            push_item(PIX_MID_GRAY, 10, 60, 1'b0);
            push_item(PIX_MID_GRAY, 10, 120, 1'b0);
            push_item(PIX_MID_GRAY, 80, 0, 1'b0);
            push_item(PIX_MID_GRAY, 80, 60, 1'b0);
            push_item(PIX_MID_GRAY, 100, 60, 1'b0);
            push_item(PIX_MID_GRAY, 80, 120, 1'b0);
            push_item(PIX_BLACK, 10, 0, 1'b0);
        end
        wait_drained();

        // Back to random traffic from the running tallies until a clear comes by
        src_idle_pct  = 16;
        sink_idle_pct = 16;
        push_random_pixels(60);
        wait_drained();

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
